[src/message_bank_keystream_decoder_unit_defines.svh]
// Assertion macros shared by the decoder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MESSAGE_BANK_KEYSTREAM_DECODER_UNIT_DEFINES_SVH
`define MESSAGE_BANK_KEYSTREAM_DECODER_UNIT_DEFINES_SVH

// cond must hold at every edge out of reset
`define MBKD_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("mbkd assertion failed");

// ante implies cons in the same cycle
`define MBKD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbkd assertion failed");

// ante implies cons in the next cycle
`define MBKD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbkd assertion failed");

`endif

[src/mbkd_pkg.sv]
// Types and constants for the message bank keystream decoder.
// No dependencies; imported by every module of the block.
package mbkd_pkg;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_TEXT   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ID  = 2'd1;
  localparam logic [1:0] ST_BAD_STR = 2'd2;

  localparam logic [1:0] REG_BANK_SEED   = 2'd0;
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd1;
  localparam logic [1:0] REG_BANK_SIZE   = 2'd2;
  localparam logic [1:0] REG_TEXT_CAP    = 2'd3;

  localparam logic [15:0] ENTRY_KEY_MUL   = 16'd765;
  localparam logic [31:0] STRING_KEY_MUL  = 32'd596947;
  // only the low half matters, key arithmetic wraps at 16 bits
  localparam logic [15:0] STRING_KEY_MUL16 = STRING_KEY_MUL[15:0];
  localparam logic [15:0] STRING_KEY_STEP = 16'd18749;
  localparam logic [19:0] SLOT_TAIL       = 20'd12;
  localparam logic [31:0] MIN_BANK_SIZE   = 32'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] entry_id;
    logic        first_unit;
    logic [15:0] cipher_unit;
    logic [31:0] enc_offset;
    logic [31:0] enc_length;
  } in_word_t;

  typedef struct packed {
    logic [15:0] plain_unit;
    logic [31:0] entry_offset;
    logic [31:0] entry_length;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] bank_seed;
    logic [15:0] entry_count;
    logic [31:0] bank_size_bytes;
    logic [31:0] text_capacity;
  } cfg_t;

  // classified word as it waits in the queue
  typedef struct packed {
    logic        command;
    logic        first_unit;
    logic [15:0] cipher_unit;
    logic [31:0] enc_offset;
    logic [31:0] enc_length;
    logic [15:0] id_p1;
    logic [15:0] seed_key;
    logic [15:0] text_key;
    logic        bad_id;
  } q_entry_t;

endpackage

[src/mbkd_front.sv]
// Front end: classifies an incoming word and precomputes its keys and id check.
// Depends on mbkd_pkg.
module mbkd_front (
  input  mbkd_pkg::in_word_t in_word,
  input  mbkd_pkg::cfg_t     cfg,
  output mbkd_pkg::q_entry_t entry
);
  import mbkd_pkg::*;

  logic [15:0] id_p1;
  logic [19:0] slot_end;

  always_comb begin
    id_p1    = in_word.entry_id + 16'd1;
    slot_end = {1'b0, in_word.entry_id, 3'b000} + SLOT_TAIL;

    entry.command     = in_word.command;
    entry.first_unit  = in_word.first_unit;
    entry.cipher_unit = in_word.cipher_unit;
    entry.enc_offset  = in_word.enc_offset;
    entry.enc_length  = in_word.enc_length;
    entry.id_p1       = id_p1;
    entry.seed_key    = 16'(cfg.bank_seed * ENTRY_KEY_MUL);
    entry.text_key    = 16'(id_p1 * STRING_KEY_MUL16);
    // table slot of 8 bytes after a 4-byte bank header must fit in the bank
    entry.bad_id      = (cfg.bank_size_bytes < MIN_BANK_SIZE)
                      || (in_word.entry_id >= cfg.entry_count)
                      || ({12'd0, slot_end} > cfg.bank_size_bytes);
  end

endmodule

[src/mbkd_queue.sv]
// Short FIFO of classified words between the front and back ends.
// Depends on mbkd_pkg for the entry type.
module mbkd_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbkd_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output mbkd_pkg::q_entry_t head,
  output logic               head_valid
);
  import mbkd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CDEPTH = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CDEPTH);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/mbkd_back.sv]
// Back end: running text key, header key multiply and string checks, output register.
// Depends on mbkd_pkg and the assertion macro header.
`include "message_bank_keystream_decoder_unit_defines.svh"

module mbkd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mbkd_pkg::cfg_t     cfg,
  input  mbkd_pkg::q_entry_t head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mbkd_pkg::out_word_t out_word
);
  import mbkd_pkg::*;

  typedef enum logic [1:0] {
    BS_RUN = 2'b01,
    BS_HDR = 2'b10
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [15:0] string_key_r, string_key_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_r, out_nxt;
  logic [15:0] key_mul_r, key_mul_nxt;
  logic [31:0] enc_off_r, enc_off_nxt;
  logic [31:0] enc_len_r, enc_len_nxt;
  logic        bad_id_r, bad_id_nxt;

  logic        out_free;
  logic [15:0] key_cur;
  logic [31:0] key_word;
  logic [31:0] off;
  logic [31:0] len;
  logic [32:0] room;
  logic        bad_str;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    key_cur  = head.first_unit ? head.text_key : string_key_r;
    key_word = {key_mul_r, key_mul_r};
    off      = enc_off_r ^ key_word;
    len      = enc_len_r ^ key_word;
    // only meaningful when off <= size, the other terms cover the rest
    room     = {1'b0, cfg.bank_size_bytes} - {1'b0, off};
    bad_str  = (len > cfg.text_capacity) || (off > cfg.bank_size_bytes)
             || ({len, 1'b0} > room);
  end

  always_comb begin
    state_nxt      = state_r;
    string_key_nxt = string_key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    key_mul_nxt    = key_mul_r;
    enc_off_nxt    = enc_off_r;
    enc_len_nxt    = enc_len_r;
    bad_id_nxt     = bad_id_r;
    pop            = 1'b0;
    unique case (state_r)
      BS_RUN: begin
        if (head_valid) begin
          if (head.command == CMD_TEXT) begin
            if (out_free) begin
              pop                 = 1'b1;
              string_key_nxt      = key_cur + STRING_KEY_STEP;
              out_valid_nxt       = 1'b1;
              out_nxt.plain_unit   = head.cipher_unit ^ key_cur;
              out_nxt.entry_offset = '0;
              out_nxt.entry_length = '0;
              out_nxt.status       = ST_OK;
            end
          end else begin
            pop         = 1'b1;
            key_mul_nxt = 16'(head.seed_key * head.id_p1);
            enc_off_nxt = head.enc_offset;
            enc_len_nxt = head.enc_length;
            bad_id_nxt  = head.bad_id;
            state_nxt   = BS_HDR;
          end
        end
      end
      BS_HDR: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.plain_unit = '0;
          if (bad_id_r) begin
            out_nxt.entry_offset = '0;
            out_nxt.entry_length = '0;
            out_nxt.status       = ST_BAD_ID;
          end else if (bad_str) begin
            out_nxt.entry_offset = '0;
            out_nxt.entry_length = '0;
            out_nxt.status       = ST_BAD_STR;
          end else begin
            out_nxt.entry_offset = off;
            out_nxt.entry_length = len;
            out_nxt.status       = ST_OK;
          end
          state_nxt = BS_RUN;
        end
      end
      default: begin
        state_nxt = BS_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_RUN;
      string_key_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      string_key_r <= string_key_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r     <= out_nxt;
    key_mul_r <= key_mul_nxt;
    enc_off_r <= enc_off_nxt;
    enc_len_r <= enc_len_nxt;
    bad_id_r  <= bad_id_nxt;
  end

  `MBKD_ASSERT_IMP(a_fail_zero, out_valid_r && (out_r.status != ST_OK), (out_r.entry_offset == '0) && (out_r.entry_length == '0))
  `MBKD_ASSERT_IMP(a_text_ok, out_valid_r && (out_r.plain_unit != '0), out_r.status == ST_OK)
  `MBKD_ASSERT_IMP(a_pop_valid, pop, head_valid)
  `MBKD_ASSERT_NEXT(a_hdr_done, (state_r == BS_HDR) && out_free, out_valid_r && (state_r == BS_RUN))

endmodule

[src/message_bank_keystream_decoder_unit.sv]
// Message bank keystream decoder. Text words (command 1) leave one per cycle
// while the output accepts and no header is in the back end; header words
// (command 0) get a key multiply, then offset/length checks, and the back end
// takes no new word while it checks. A queue of QUEUE_DEPTH words between front
// and back keeps the input accepting while a header is worked on or the output
// stalls. Registers sit at byte addresses 0 (bank seed), 4 (entry count),
// 8 (bank size) and 12 (text capacity).
// Depends on mbkd_pkg, mbkd_front, mbkd_queue and mbkd_back.
module message_bank_keystream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbkd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mbkd_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mbkd_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  q_entry_t    front_entry;
  q_entry_t    head;
  logic        head_valid;
  logic        q_full;
  logic        pop;
  logic        push;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BANK_SEED:   cfg_nxt.bank_seed       = pwdata[15:0];
        REG_ENTRY_COUNT: cfg_nxt.entry_count     = pwdata[15:0];
        REG_BANK_SIZE:   cfg_nxt.bank_size_bytes = pwdata;
        REG_TEXT_CAP:    cfg_nxt.text_capacity   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BANK_SEED:   prdata = {16'd0, cfg_r.bank_seed};
      REG_ENTRY_COUNT: prdata = {16'd0, cfg_r.entry_count};
      REG_BANK_SIZE:   prdata = cfg_r.bank_size_bytes;
      REG_TEXT_CAP:    prdata = cfg_r.text_capacity;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  mbkd_front u_front (
    .in_word (in_data),
    .cfg     (cfg_r),
    .entry   (front_entry)
  );

  mbkd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  mbkd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_data)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for message_bank_keystream_decoder_unit.
// Drives header and text words through valid/ready and the registers through APB.
// A scoreboard predicts every result. Depends on mbkd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import mbkd_pkg::*;

  localparam logic [31:0] ENTRY_MUL   = 32'd765;
  localparam logic [31:0] STRING_MUL  = 32'd596947;
  localparam logic [15:0] STRING_STEP = 16'd18749;

  class decode_checker;
    logic [15:0] seed;
    logic [15:0] count;
    logic [31:0] size;
    logic [31:0] cap;
    logic [15:0] text_key;
    out_word_t   pending_words[$];
    int          mismatches;

    function new();
      seed = '0;
      count = '0;
      size = '0;
      cap = '0;
      text_key = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_BANK_SEED:   seed = v[15:0];
        REG_ENTRY_COUNT: count = v[15:0];
        REG_BANK_SIZE:   size = v;
        default:         cap = v;
      endcase
    endfunction

    // entry key repeated in both halves
    function logic [31:0] entry_word(logic [15:0] id);
      logic [31:0] k;
      k = (32'(seed) * ENTRY_MUL) & 32'h0000_FFFF;
      k = (k * (32'(id) + 32'd1)) & 32'h0000_FFFF;
      return {k[15:0], k[15:0]};
    endfunction

    function out_word_t decode_word(in_word_t w);
      out_word_t   r;
      logic [31:0] kw, off, len, t;
      r = '0;
      if (w.command == CMD_TEXT) begin
        if (w.first_unit) begin
          t = (32'(w.entry_id) + 32'd1) * STRING_MUL;
          text_key = t[15:0];
        end
        r.plain_unit = w.cipher_unit ^ text_key;
        text_key = text_key + STRING_STEP;
      end else if (size < 32'd4 || w.entry_id >= count ||
                   64'(w.entry_id) * 64'd8 + 64'd12 > 64'(size)) begin
        r.status = ST_BAD_ID;
      end else begin
        kw = entry_word(w.entry_id);
        off = w.enc_offset ^ kw;
        len = w.enc_length ^ kw;
        if (len > cap || off > size || 64'(len) * 64'd2 > 64'(size) - 64'(off)) begin
          r.status = ST_BAD_STR;
        end else begin
          r.entry_offset = off;
          r.entry_length = len;
          r.status = ST_OK;
        end
      end
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending_words.push_back(decode_word(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: plain %h off %h len %h status %0d",
                   got.plain_unit, got.entry_offset, got.entry_length, got.status);
        return;
      end
      want = pending_words.pop_front();
      if (got.plain_unit !== want.plain_unit || got.entry_offset !== want.entry_offset ||
          got.entry_length !== want.entry_length || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want plain %h off %h len %h status %0d",
                   want.plain_unit, want.entry_offset, want.entry_length, want.status);
          $display("          got  plain %h off %h len %h status %0d",
                   got.plain_unit, got.entry_offset, got.entry_length, got.status);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic          holding = 1'b0;
  int            send_idle = 0;
  int            recv_stall = 0;
  decode_checker sb;

  message_bank_keystream_decoder_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= !holding && ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic offer_word(input in_word_t w);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_word_t header_word(logic [15:0] id, logic [31:0] off,
                                           logic [31:0] len);
    in_word_t w;
    logic [31:0] kw;
    kw = sb.entry_word(id);
    w.command = CMD_HEADER;
    w.entry_id = id;
    w.first_unit = 1'($urandom_range(0, 1));
    w.cipher_unit = 16'($urandom);
    w.enc_offset = off ^ kw;
    w.enc_length = len ^ kw;
    return w;
  endfunction

  function automatic in_word_t text_word(logic [15:0] id, logic first, logic [15:0] c);
    in_word_t w;
    w.command = CMD_TEXT;
    w.entry_id = id;
    w.first_unit = first;
    w.cipher_unit = c;
    w.enc_offset = $urandom;
    w.enc_length = $urandom;
    return w;
  endfunction

  // mostly text streams and well-formed headers, some raw noise
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [31:0] id_max, len_max, off, len;
    int          pick;
    pick = $urandom_range(0, 99);
    w.command = CMD_HEADER;
    w.entry_id = 16'($urandom);
    w.first_unit = 1'($urandom_range(0, 1));
    w.cipher_unit = 16'($urandom);
    w.enc_offset = $urandom;
    w.enc_length = $urandom;
    if (pick < 55) begin
      w.command = CMD_TEXT;
      w.first_unit = ($urandom_range(0, 5) == 0);
    end else if (pick < 88 && sb.count != 0 && sb.size >= 32'd12) begin
      id_max = (sb.size - 32'd12) / 32'd8;
      if (id_max > 32'(sb.count) - 32'd1) id_max = 32'(sb.count) - 32'd1;
      off = ($urandom_range(0, 3) == 0) ? sb.size : $urandom_range(0, sb.size);
      if ($urandom_range(0, 1) == 0 && sb.size > 32'd64)
        off = $urandom_range(0, 64);
      len_max = (sb.size - off) / 32'd2;
      if (len_max > sb.cap) len_max = sb.cap;
      case ($urandom_range(0, 7))
        0:       len = len_max + 32'd1;
        1:       len = len_max;
        default: len = $urandom_range(0, len_max);
      endcase
      w = header_word(16'($urandom_range(0, id_max)), off, len);
    end else if (pick >= 88 && sb.count != 0) begin
      w.entry_id = sb.count - 16'($urandom_range(0, 1));
    end
    return w;
  endfunction

  task automatic random_config();
    logic [31:0] v;
    write_reg(REG_BANK_SEED, $urandom);
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(1, 64);
      1:       v = 32'hFFFF;
      default: v = $urandom;
    endcase
    write_reg(REG_ENTRY_COUNT, v);
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(12, 4096);
      1:       v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(REG_BANK_SIZE, v);
    case ($urandom_range(0, 2))
      0:       v = $urandom_range(0, 2048);
      1:       v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(REG_TEXT_CAP, v);
  endtask

  initial begin
    in_word_t w;
    int       idle_sets[4][2];
    sb = new();
    idle_sets = '{'{0, 0}, '{70, 0}, '{0, 70}, '{33, 33}};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: key starts at zero, bank too small
    offer_word(text_word(16'h0042, 1'b0, 16'hABCD));
    offer_word(text_word(16'hFFFF, 1'b0, 16'hFFFF));
    offer_word(header_word(16'h0000, 32'd0, 32'd0));
    drain_pending();

    write_reg(REG_BANK_SEED, 32'h1234);
    write_reg(REG_ENTRY_COUNT, 32'd100);
    write_reg(REG_BANK_SIZE, 32'd4096);
    write_reg(REG_TEXT_CAP, 32'd1000);
    offer_word(header_word(16'd0, 32'd100, 32'd20));
    offer_word(header_word(16'd99, 32'd4096, 32'd0));
    offer_word(header_word(16'd100, 32'd0, 32'd0));     // id past count
    offer_word(header_word(16'd5, 32'd0, 32'd1001));    // over capacity
    offer_word(header_word(16'd5, 32'd4097, 32'd0));    // offset past bank
    offer_word(header_word(16'd5, 32'd3000, 32'd549));  // string runs off the end
    offer_word(header_word(16'd5, 32'd3000, 32'd548));
    offer_word(text_word(16'd0, 1'b1, 16'h0000));
    offer_word(text_word(16'd0, 1'b0, 16'hFFFF));
    offer_word(text_word(16'd7, 1'b0, 16'h1234));
    offer_word(text_word(16'hFFFF, 1'b1, 16'h5555));    // id+1 wraps
    offer_word(text_word(16'h8000, 1'b0, 16'hAAAA));
    drain_pending();

    write_reg(REG_BANK_SEED, 32'hFFFF);
    write_reg(REG_ENTRY_COUNT, 32'hFFFF);
    write_reg(REG_BANK_SIZE, 32'hFFFF_FFFF);
    write_reg(REG_TEXT_CAP, 32'hFFFF_FFFF);
    offer_word(header_word(16'hFFFE, 32'd1, 32'h7FFF_FFFF));
    offer_word(header_word(16'hFFFF, 32'd0, 32'd0));
    offer_word(header_word(16'd0, 32'd0, 32'hFFFF_FFFF));
    offer_word(header_word(16'd1, 32'hFFFF_FFFF, 32'd0));
    w = text_word(16'd3, 1'b1, 16'hFFFF);
    w.command = CMD_HEADER;
    w.enc_offset = 32'hFFFF_FFFF;
    w.enc_length = 32'hFFFF_FFFF;
    offer_word(w);
    drain_pending();

    // table slot just fits, next one lies beyond the bank
    write_reg(REG_BANK_SEED, 32'd1);
    write_reg(REG_ENTRY_COUNT, 32'd10);
    write_reg(REG_BANK_SIZE, 32'd20);
    write_reg(REG_TEXT_CAP, 32'd0);
    offer_word(header_word(16'd1, 32'd20, 32'd0));
    offer_word(header_word(16'd2, 32'd0, 32'd0));
    offer_word(header_word(16'd0, 32'd0, 32'd1));
    drain_pending();
    write_reg(REG_BANK_SIZE, 32'd3);
    offer_word(header_word(16'd0, 32'd0, 32'd0));
    drain_pending();

    for (int ph = 0; ph < 4; ph++) begin
      random_config();
      send_idle = idle_sets[ph][0];
      recv_stall = idle_sets[ph][1];
      if (ph == 0) begin
        // long output hold-off while input keeps coming, fills the queue
        fork
          begin
            repeat (30) @(posedge clk);
            holding <= 1'b1;
            repeat (120) @(posedge clk);
            holding <= 1'b0;
          end
        join_none
      end
      repeat (300) offer_word(random_word());
      drain_pending();
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

[message_bank_keystream_decoder_unit.f]
+incdir+src
src/mbkd_pkg.sv
src/mbkd_front.sv
src/mbkd_queue.sv
src/mbkd_back.sv
src/message_bank_keystream_decoder_unit.sv
tb/testbench.sv
